### design/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion macros, clocked on clk_i and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define ASSERT_PROP(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

`define ASSERT_NEVER(lbl, cond, msg) \
  `ASSERT_PROP(lbl, !(cond), msg)

`else

`define ASSERT_PROP(lbl, prop, msg)

`define ASSERT_NEVER(lbl, cond, msg)

`endif

`endif

### design/fsic_pkg.sv
// ----------------------------------------------------------------------------
// fsic_pkg
// Shared constants, types and the controller/datapath interface structs.
// ----------------------------------------------------------------------------
package fsic_pkg;

  localparam int unsigned MaxUnique = 1024;
  localparam int unsigned AddrW     = $clog2(MaxUnique);
  localparam int unsigned CntW      = $clog2(MaxUnique + 1);
  localparam int unsigned KeyW      = 32;
  localparam int unsigned OutW      = 10;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_SCAN = 1'b1
  } state_e;

  // controller -> datapath
  typedef struct packed {
    logic load;       // capture transaction, restart scan
    logic issue;      // read table at scan pointer
    logic done_hit;   // answer with matched position
    logic done_miss;  // answer as unseen (store if room)
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic hit;        // registered read data matches key
    logic more;       // scan pointer below fill count
    logic drained;    // nothing left to read or compare
  } status_t;

endpackage

### design/first_seen_index_compactor_unit.sv
// ----------------------------------------------------------------------------
// first_seen_index_compactor_unit
// Dense renumbering of 32-bit vertex indices in order of first appearance.
// ----------------------------------------------------------------------------
// Scan: an empty table is answered without a table read; a hit ends the scan
//   at the matching entry, a miss reads every filled entry (one table read per cycle).
// Throughput: one transaction at a time; busy falls as the result is
//   registered, so the next start can be taken while strobe_o is high.
// Reset: asynchronous, active low; clears the FSM and the fill count, so the
//   table is empty at once. Key memory is not cleared. Results cannot stall.
// ----------------------------------------------------------------------------
module first_seen_index_compactor_unit (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  // command side
  input  logic                      start,
  output logic                      busy,
  input  logic [fsic_pkg::KeyW-1:0] index_value_i,
  input  logic                      last_in_set_i,
  // result side: one-cycle strobe, no back pressure
  output logic                      strobe_o,
  output logic [fsic_pkg::OutW-1:0] new_index_o,
  output logic                      first_seen_o,
  output logic                      table_full_o
);

  // The controller walks the table from entry 0 up to the fill count.
  // Reads are pipelined: one address goes out each cycle while the data of
  // the previous one is compared with the held key. A match ends the scan
  // early; an empty pipe with the pointer at the fill count is a miss, and
  // the key is appended at the fill count unless the table is full.
  fsic_pkg::cmd_t    cmd;
  fsic_pkg::status_t status;

  fsic_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start),
    .status_i (status),
    .cmd_o    (cmd),
    .busy_o   (busy)
  );

  // Table, fill count and result registers; the last-in-set flag held with
  // the key drops the fill count to zero when the transaction is answered.
  fsic_dpath u_dpath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .status_o      (status),
    .index_value_i (index_value_i),
    .last_in_set_i (last_in_set_i),
    .strobe_o      (strobe_o),
    .new_index_o   (new_index_o),
    .first_seen_o  (first_seen_o),
    .table_full_o  (table_full_o)
  );

endmodule

### design/fsic_ctrl.sv
// ----------------------------------------------------------------------------
// fsic_ctrl
// Controller FSM: sequences the table scan and decides hit or miss.
// ----------------------------------------------------------------------------
module fsic_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  fsic_pkg::status_t status_i,
  output fsic_pkg::cmd_t    cmd_o,
  output logic              busy_o
);

  fsic_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= fsic_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      fsic_pkg::ST_IDLE: begin
        if (start_i) state_d = fsic_pkg::ST_SCAN;
      end
      fsic_pkg::ST_SCAN: begin
        if (status_i.hit || status_i.drained) state_d = fsic_pkg::ST_IDLE;
      end
      default: state_d = fsic_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o  = '0;
    busy_o = 1'b0;
    unique case (state_q)
      fsic_pkg::ST_IDLE: begin
        cmd_o.load = start_i;
      end
      fsic_pkg::ST_SCAN: begin
        busy_o          = 1'b1;
        cmd_o.done_hit  = status_i.hit;
        cmd_o.done_miss = !status_i.hit && status_i.drained;
        cmd_o.issue     = !status_i.hit && status_i.more;
      end
      default: begin
        cmd_o  = '0;
        busy_o = 1'b0;
      end
    endcase
  end

endmodule

### design/fsic_dpath.sv
// ----------------------------------------------------------------------------
// fsic_dpath
// Datapath: key table memory, scan pointer, fill count, result registers.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module fsic_dpath (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  fsic_pkg::cmd_t                cmd_i,
  output fsic_pkg::status_t             status_o,
  input  logic [fsic_pkg::KeyW-1:0]     index_value_i,
  input  logic                          last_in_set_i,
  output logic                          strobe_o,
  output logic [fsic_pkg::OutW-1:0]     new_index_o,
  output logic                          first_seen_o,
  output logic                          table_full_o
);

  logic [fsic_pkg::KeyW-1:0]  mem_q [fsic_pkg::MaxUnique];

  logic [fsic_pkg::KeyW-1:0]  key_q;
  logic                       last_q;
  logic [fsic_pkg::CntW-1:0]  ptr_q, ptr_d;
  logic [fsic_pkg::CntW-1:0]  fill_q, fill_d;
  logic                       rd_vld_q, rd_vld_d;
  logic [fsic_pkg::AddrW-1:0] rd_pos_q;
  logic [fsic_pkg::KeyW-1:0]  rd_data_q;
  logic                       strobe_q, strobe_d;
  logic [fsic_pkg::OutW-1:0]  new_index_q, new_index_d;
  logic                       first_q, first_d;
  logic                       full_q, full_d;
  logic                       tbl_full;
  logic                       store;

  assign tbl_full = (fill_q == fsic_pkg::CntW'(fsic_pkg::MaxUnique));
  assign store    = cmd_i.done_miss && !tbl_full;

  assign status_o.hit     = rd_vld_q && (rd_data_q == key_q);
  assign status_o.more    = (ptr_q < fill_q);
  assign status_o.drained = !rd_vld_q && !(ptr_q < fill_q);

  // table memory: one write port at the fill count, one registered read port
  always_ff @(posedge clk_i) begin
    if (store) begin
      mem_q[fill_q[fsic_pkg::AddrW-1:0]] <= key_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.issue) begin
      rd_data_q <= mem_q[ptr_q[fsic_pkg::AddrW-1:0]];
      rd_pos_q  <= ptr_q[fsic_pkg::AddrW-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      key_q  <= index_value_i;
      last_q <= last_in_set_i;
    end
  end

  always_comb begin
    ptr_d       = ptr_q;
    rd_vld_d    = cmd_i.issue;
    fill_d      = fill_q;
    strobe_d    = cmd_i.done_hit || cmd_i.done_miss;
    new_index_d = new_index_q;
    first_d     = first_q;
    full_d      = full_q;
    if (cmd_i.load) begin
      ptr_d    = '0;
      rd_vld_d = 1'b0;
    end else if (cmd_i.issue) begin
      ptr_d = ptr_q + fsic_pkg::CntW'(1);
    end
    if (cmd_i.done_hit) begin
      new_index_d = fsic_pkg::OutW'(rd_pos_q);
      first_d     = 1'b0;
      full_d      = 1'b0;
    end else if (cmd_i.done_miss) begin
      first_d = 1'b1;
      full_d  = tbl_full;
      if (tbl_full) begin
        new_index_d = '0;
      end else begin
        new_index_d = fsic_pkg::OutW'(fill_q);
        fill_d      = fill_q + fsic_pkg::CntW'(1);
      end
    end
    if ((cmd_i.done_hit || cmd_i.done_miss) && last_q) begin
      fill_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ptr_q    <= '0;
      fill_q   <= '0;
      rd_vld_q <= 1'b0;
      strobe_q <= 1'b0;
    end else begin
      ptr_q    <= ptr_d;
      fill_q   <= fill_d;
      rd_vld_q <= rd_vld_d;
      strobe_q <= strobe_d;
    end
  end

  always_ff @(posedge clk_i) begin
    new_index_q <= new_index_d;
    first_q     <= first_d;
    full_q      <= full_d;
  end

  assign strobe_o     = strobe_q;
  assign new_index_o  = new_index_q;
  assign first_seen_o = first_q;
  assign table_full_o = full_q;

  `ASSERT_PROP(a_fill_bound, fill_q <= fsic_pkg::CntW'(fsic_pkg::MaxUnique), "fill count overflow")
  `ASSERT_NEVER(a_done_excl, cmd_i.done_hit && cmd_i.done_miss, "hit and miss together")
  `ASSERT_PROP(a_hit_below_fill, status_o.hit |-> ({1'b0, rd_pos_q} < fill_q), "hit beyond fill")
  `ASSERT_PROP(a_strobe_src, strobe_o |-> $past(cmd_i.done_hit || cmd_i.done_miss), "stray strobe")

endmodule
